// ----- rtl/core/bat_pkg.sv -----
// Package: shared constants, codes and types for the breakpoint address table.
`default_nettype none
package bat_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 8;
   localparam int ADDR_W              = 8;
   localparam int OP_W                = 2;
   localparam int STATUS_W            = 2;
   localparam int COUNT_OUT_W         = 4;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_MATCH  = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_PRESENT   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MOVE
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/core/bat_store.sv -----
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
module bat_store #(
   parameter int MAX_ENTRIES = bat_pkg::MAX_ENTRIES_DEFAULT,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [IDX_W-1:0]          wr_addr,
   input  wire logic [bat_pkg::ADDR_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [IDX_W-1:0]          rd_addr,
   output logic      [bat_pkg::ADDR_W-1:0] rd_data
);

   logic [bat_pkg::ADDR_W-1:0] mem [0:MAX_ENTRIES-1];
   logic [bat_pkg::ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/bat_ctrl.sv -----
// Sequencer: scans the entries, decides the operation and writes back.
`default_nettype none
module bat_ctrl #(
   parameter int MAX_ENTRIES = bat_pkg::MAX_ENTRIES_DEFAULT,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [bat_pkg::OP_W-1:0]     req_opcode,
   input  wire logic [bat_pkg::ADDR_W-1:0]   req_address,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic      [bat_pkg::STATUS_W-1:0] rsp_status,
   output logic      [CNT_W-1:0]             rsp_count,
   output logic                              mem_wr_en,
   output logic      [IDX_W-1:0]             mem_wr_addr,
   output logic      [bat_pkg::ADDR_W-1:0]   mem_wr_data,
   output logic                              mem_rd_en,
   output logic      [IDX_W-1:0]             mem_rd_addr,
   input  wire logic [bat_pkg::ADDR_W-1:0]   mem_rd_data
);

   bat_pkg::state_type state_ff, state_in;

   logic [bat_pkg::OP_W-1:0]     op_ff, op_in;
   logic [bat_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [IDX_W-1:0]             slot_ff, slot_in;
   logic                         hit_ff, hit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [bat_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]             rsp_count_ff, rsp_count_in;

   logic match;
   logic last;

   assign match = (mem_rd_data == addr_ff);
   assign last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bat_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (count_ff == '0) ? bat_pkg::ST_DECIDE : bat_pkg::ST_SCAN;
            end
         end
         bat_pkg::ST_SCAN: begin
            if (match || last) begin
               state_in = bat_pkg::ST_DECIDE;
            end
         end
         bat_pkg::ST_DECIDE: begin
            if (op_ff == bat_pkg::OP_REMOVE && hit_ff) begin
               state_in = bat_pkg::ST_MOVE;
            end else begin
               state_in = bat_pkg::ST_IDLE;
            end
         end
         bat_pkg::ST_MOVE: begin
            state_in = bat_pkg::ST_IDLE;
         end
         default: state_in = bat_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in         = op_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = addr_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ff;
      unique case (state_ff)
         bat_pkg::ST_IDLE: begin
            if (start) begin
               op_in       = req_opcode;
               addr_in     = req_address;
               hit_in      = 1'b0;
               idx_in      = '0;
               mem_rd_en   = 1'b1;
               mem_rd_addr = '0;
            end
         end
         bat_pkg::ST_SCAN: begin
            if (match) begin
               hit_in  = 1'b1;
               slot_in = idx_ff;
            end else if (!last) begin
               idx_in      = idx_ff + IDX_W'(1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff + IDX_W'(1);
            end
         end
         bat_pkg::ST_DECIDE: begin
            rsp_hit_in    = hit_ff;
            rsp_status_in = bat_pkg::STAT_DONE;
            rsp_valid_in  = 1'b1;
            unique case (op_ff)
               bat_pkg::OP_ADD: begin
                  if (hit_ff) begin
                     rsp_status_in = bat_pkg::STAT_PRESENT;
                  end else if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                     rsp_status_in = bat_pkg::STAT_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = IDX_W'(count_ff);
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               bat_pkg::OP_REMOVE: begin
                  if (hit_ff) begin
                     // fetch the last entry, result follows the move
                     rsp_valid_in = 1'b0;
                     mem_rd_en    = 1'b1;
                     mem_rd_addr  = IDX_W'(count_ff - CNT_W'(1));
                  end else begin
                     rsp_status_in = bat_pkg::STAT_NOT_FOUND;
                  end
               end
               bat_pkg::OP_CLEAR: begin
                  count_in = '0;
               end
               bat_pkg::OP_MATCH: begin
                  if (!hit_ff) begin
                     rsp_status_in = bat_pkg::STAT_NOT_FOUND;
                  end
               end
               default: rsp_status_in = bat_pkg::STAT_DONE;
            endcase
         end
         bat_pkg::ST_MOVE: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = slot_ff;
            mem_wr_data   = mem_rd_data;
            count_in      = count_ff - CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_hit_in    = 1'b1;
            rsp_status_in = bat_pkg::STAT_DONE;
         end
         default: rsp_valid_in = 1'b0;
      endcase
      rsp_count_in = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bat_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      slot_ff       <= slot_in;
      hit_ff        <= hit_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy       = (state_ff != bat_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule
`default_nettype wire

// ----- rtl/core/breakpoint_address_table.sv -----
// Top level: breakpoint address table with entry memory and sequencer.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  request   | start, busy        | req_opcode[1:0], req_address[7:0]
//  response  | rsp_valid (strobe) | rsp_hit, rsp_status[1:0], rsp_entry_count[3:0]
//
// A request is taken when start is high and busy is low. The sequencer then
// reads one entry per cycle (k compares, 1 <= k <= count, stopping at the
// first hit; none on an empty table), then decides, and on a remove hit
// moves the last entry into the freed slot. The result strobe is registered
// from the decide step, or from the move step on a remove hit.
// Reset zeroes the entry count; entry memory contents are not cleared.
// The result is shown for one cycle and cannot be stalled.
`default_nettype none
module breakpoint_address_table #(
   parameter int MAX_ENTRIES = bat_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [bat_pkg::OP_W-1:0]         req_opcode,
   input  wire logic [bat_pkg::ADDR_W-1:0]       req_address,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic      [bat_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [bat_pkg::COUNT_OUT_W-1:0]  rsp_entry_count
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic                       mem_wr_en;
   logic [IDX_W-1:0]           mem_wr_addr;
   logic [bat_pkg::ADDR_W-1:0] mem_wr_data;
   logic                       mem_rd_en;
   logic [IDX_W-1:0]           mem_rd_addr;
   logic [bat_pkg::ADDR_W-1:0] mem_rd_data;
   logic [CNT_W-1:0]           rsp_count;

   bat_store #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bat_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_opcode  (req_opcode),
      .req_address (req_address),
      .rsp_valid   (rsp_valid),
      .rsp_hit     (rsp_hit),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // count shown modulo 16
   assign rsp_entry_count = bat_pkg::COUNT_OUT_W'(rsp_count);

endmodule
`default_nettype wire

// ----- tb/tb_breakpoint_address_table.sv -----
// Self-checking testbench for the breakpoint address table: directed corners then random traffic.
`default_nettype none
module tb_breakpoint_address_table;
   timeunit 1ns;
   timeprecision 1ps;

   import bat_pkg::*;

   localparam int TABLE_DEPTH = MAX_ENTRIES_DEFAULT;
   localparam int RANDOM_ITEMS = 450;

   typedef struct packed {
      logic                   hit;
      logic [STATUS_W-1:0]    status;
      logic [COUNT_OUT_W-1:0] entry_count;
   } bp_rsp_t;

   class bp_table_scoreboard;
      logic [ADDR_W-1:0] bp_addr[TABLE_DEPTH];
      int                bp_count;
      bp_rsp_t           expected_rsp[$];
      int                fail_count;
      int                checked;
      int                op_seen[4];
      int                hits_seen;
      int                full_seen;

      function new();
         bp_count   = 0;
         fail_count = 0;
         checked    = 0;
         hits_seen  = 0;
         full_seen  = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
         int      slot;
         bp_rsp_t rsp;
         slot = -1;
         for (int i = 0; i < bp_count; i++) begin
            if (slot < 0 && bp_addr[i] == addr) slot = i;
         end
         rsp.hit    = (slot >= 0);
         rsp.status = STAT_DONE;
         case (op)
            OP_ADD: begin
               if (slot >= 0) begin
                  rsp.status = STAT_PRESENT;
               end else if (bp_count >= TABLE_DEPTH) begin
                  rsp.status = STAT_FULL;
                  full_seen++;
               end else begin
                  bp_addr[bp_count] = addr;
                  bp_count++;
               end
            end
            OP_REMOVE: begin
               if (slot >= 0) begin
                  bp_addr[slot] = bp_addr[bp_count-1];
                  bp_count--;
               end else begin
                  rsp.status = STAT_NOT_FOUND;
               end
            end
            OP_CLEAR: begin
               bp_count = 0;
            end
            default: begin
               if (slot < 0) rsp.status = STAT_NOT_FOUND;
            end
         endcase
         rsp.entry_count = COUNT_OUT_W'(bp_count);
         if (rsp.hit) hits_seen++;
         op_seen[op]++;
         expected_rsp.push_back(rsp);
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns  mismatch: %s", $time, msg);
         fail_count++;
      endtask

      task check_response(logic hit, logic [STATUS_W-1:0] status,
                          logic [COUNT_OUT_W-1:0] entry_count);
         bp_rsp_t want;
         if (expected_rsp.size() == 0) begin
            report_mismatch("response strobe with no item outstanding");
            return;
         end
         want = expected_rsp.pop_front();
         checked++;
         if (hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
         if (entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, want %0d",
                                      entry_count, want.entry_count));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [OP_W-1:0]        req_opcode = OP_MATCH;
   logic [ADDR_W-1:0]      req_address = '0;
   logic                   rsp_valid;
   logic                   rsp_hit;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;

   bp_table_scoreboard tbl = new();
   logic [ADDR_W-1:0]  addr_pool[11];
   bit                 no_idle = 1'b0;

   breakpoint_address_table #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_address    (req_address),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_status     (rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         tbl.check_response(rsp_hit, rsp_status, rsp_entry_count);
   end

   task send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start       <= 1'b1;
      req_opcode  <= op;
      req_address <= addr;
      do @(posedge clock); while (busy !== 1'b0);
      tbl.note_request(op, addr);
   endtask

   function logic [ADDR_W-1:0] pick_address();
      if ($urandom_range(0, 9) < 7) return addr_pool[$urandom_range(0, 10)];
      return ADDR_W'($urandom_range(0, 255));
   endfunction

   function logic [OP_W-1:0] pick_opcode();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return OP_ADD;
      if (roll < 65) return OP_REMOVE;
      if (roll < 70) return OP_CLEAR;
      return OP_MATCH;
   endfunction

   initial begin
      int waited;
      addr_pool[0] = 8'h00;
      addr_pool[1] = 8'hFF;
      for (int i = 2; i < 11; i++) addr_pool[i] = ADDR_W'($urandom_range(0, 255));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table corners
      send_item(OP_MATCH,  8'h00);
      send_item(OP_REMOVE, 8'hFF);
      send_item(OP_CLEAR,  8'h5A);
      // fill to capacity, duplicate on the way
      send_item(OP_ADD,    8'h00);
      send_item(OP_ADD,    8'hFF);
      send_item(OP_ADD,    8'hFF);
      send_item(OP_MATCH,  8'hFF);
      send_item(OP_MATCH,  8'h00);
      send_item(OP_ADD,    8'h01);
      send_item(OP_ADD,    8'h80);
      send_item(OP_ADD,    8'h7F);
      send_item(OP_ADD,    8'hAA);
      send_item(OP_ADD,    8'h55);
      send_item(OP_ADD,    8'hFE);
      send_item(OP_ADD,    8'h10);
      send_item(OP_ADD,    8'h00);
      // remove first slot, first slot again (FE moved in), absent
      send_item(OP_REMOVE, 8'h00);
      send_item(OP_REMOVE, 8'hFE);
      send_item(OP_REMOVE, 8'h42);
      send_item(OP_MATCH,  8'h80);
      send_item(OP_MATCH,  8'h42);
      send_item(OP_CLEAR,  8'h80);
      send_item(OP_MATCH,  8'h80);
      send_item(OP_CLEAR,  8'h80);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         send_item(pick_opcode(), pick_address());
      end
      @(negedge clock);
      start <= 1'b0;

      waited = 0;
      while (tbl.pending() > 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (tbl.pending() > 0)
         tbl.report_mismatch($sformatf("%0d responses never arrived", tbl.pending()));

      $display("Items: %0d add, %0d remove, %0d clear, %0d match; %0d responses checked",
               tbl.op_seen[OP_ADD], tbl.op_seen[OP_REMOVE], tbl.op_seen[OP_CLEAR],
               tbl.op_seen[OP_MATCH], tbl.checked);
      $display("Hits %0d, full-table drops %0d, mismatches %0d",
               tbl.hits_seen, tbl.full_seen, tbl.fail_count);
      if (tbl.fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d responses outstanding", tbl.pending());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/bat_pkg.sv
rtl/core/bat_store.sv
rtl/core/bat_ctrl.sv
rtl/core/breakpoint_address_table.sv
tb/tb_breakpoint_address_table.sv
